@@ design/hhf_pkg.sv @@
package hhf_pkg;

   // default sizes of the name stores
   localparam int NAME_BYTES_DEF    = 256;
   localparam int BLACK_ENTRIES_DEF = 16;
   localparam int WHITE_ENTRIES_DEF = 16;

   // length field wide enough for the largest supported name size
   localparam int LEN_MAX_W = 11;

   // input opcodes
   typedef logic [1:0] opcode_type;
   localparam opcode_type OP_PAYLOAD = 2'd0;
   localparam opcode_type OP_BLACK   = 2'd1;
   localparam opcode_type OP_WHITE   = 2'd2;
   localparam opcode_type OP_NONE    = 2'd3;

   // result reasons
   typedef logic [2:0] reason_type;
   localparam reason_type REASON_DISABLED  = 3'd0;
   localparam reason_type REASON_NO_METHOD = 3'd1;
   localparam reason_type REASON_NO_HOST   = 3'd2;
   localparam reason_type REASON_WHITE     = 3'd3;
   localparam reason_type REASON_BLACK     = 3'd4;
   localparam reason_type REASON_UNLISTED  = 3'd5;
   localparam reason_type REASON_INSERTED  = 3'd6;
   localparam reason_type REASON_DUPLICATE = 3'd7;

   // characters the parser looks for
   localparam logic [7:0] CH_CR  = 8'h0D;
   localparam logic [7:0] CH_LF  = 8'h0A;
   localparam logic [7:0] CH_NUL = 8'h00;
   localparam logic [7:0] CH_G   = 8'h47;
   localparam logic [7:0] CH_P   = 8'h50;
   localparam logic [7:0] CH_H   = 8'h48;
   localparam logic [2:0] HOST_KEY_LEN = 3'd6;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [7:0]  data_byte;
      logic        last;
      logic [47:0] station_mac;
   } req_type;

   typedef struct packed {
      logic        verdict;
      logic [2:0]  reason;
      logic [7:0]  host_length;
      logic [31:0] redirect_count;
   } rsp_type;

   typedef enum logic [2:0] {
      JOB_DISABLED,
      JOB_NO_METHOD,
      JOB_JUDGE,
      JOB_BLACK_INS,
      JOB_WHITE_INS
   } job_kind_type;

   typedef struct packed {
      job_kind_type         kind;
      logic [47:0]          mac;
      logic [LEN_MAX_W-1:0] len;
   } job_type;

   typedef struct packed {
      logic                 we;
      logic [LEN_MAX_W-1:0] addr;
      logic [7:0]           data;
   } stg_wr_type;

   // "Host: " key
   function automatic logic [7:0] host_key(input logic [2:0] pos);
      logic [7:0] ch;
      case (pos)
         3'd0: ch = 8'h48;
         3'd1: ch = 8'h6F;
         3'd2: ch = 8'h73;
         3'd3: ch = 8'h74;
         3'd4: ch = 8'h3A;
         default: ch = 8'h20;
      endcase
      return ch;
   endfunction

   // host length reported on the result, saturated to eight bits
   function automatic logic [7:0] sat_len(input logic [LEN_MAX_W-1:0] len);
      return (|len[LEN_MAX_W-1:8]) ? 8'hFF : len[7:0];
   endfunction

endpackage

@@ design/hhf_job_fifo.sv @@
module hhf_job_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_i,
   input  hhf_pkg::job_type  data_i,
   input  logic              pop_i,
   output logic              full_o,
   output logic              empty_o,
   output hhf_pkg::job_type  data_o
);

   hhf_pkg::job_type mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign full_o  = count_ff == 2'd2;
   assign empty_o = count_ff == 2'd0;
   assign data_o  = mem_ff[rd_ptr_ff];
   assign do_push = push_i && !full_o;
   assign do_pop  = pop_i && !empty_o;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= data_i;
      end
   end

endmodule

@@ design/hhf_front.sv @@
module hhf_front #(
   parameter int NAME_BYTES = hhf_pkg::NAME_BYTES_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   output logic                full,
   input  hhf_pkg::req_type    req_data,
   input  logic                csr_write_enable,
   input  logic                csr_write_data,
   input  logic                fifo_full_i,
   input  logic                stg_release_i,
   output logic                job_push_o,
   output hhf_pkg::job_type    job_o,
   output hhf_pkg::stg_wr_type stg_wr_o
);

   localparam int LW = $clog2(NAME_BYTES + 1);

   typedef enum logic [10:0] {
      PH_IDLE     = 11'b00000000001,
      PH_SKIP     = 11'b00000000010,
      PH_LINE     = 11'b00000000100,
      PH_CR       = 11'b00000001000,
      PH_MATCH    = 11'b00000010000,
      PH_HOST     = 11'b00000100000,
      PH_DONE     = 11'b00001000000,
      PH_BLK      = 11'b00010000000,
      PH_BLK_SHUT = 11'b00100000000,
      PH_WHT      = 11'b01000000000,
      PH_WHT_SHUT = 11'b10000000000
   } phase_type;

   phase_type   phase_ff, phase_in, ph;
   logic [LW-1:0] len_ff, len_in, ln;
   logic [2:0]  mp_ff, mp_in, mp;
   logic        enable_ff, enable_in;
   logic        busy_ff, busy_in;
   logic        accept;
   logic [1:0]  cur_stream;
   logic        emitted;

   // which stream an unfinished item belongs to: none, packet, black, white
   function automatic logic [1:0] stream_of(input phase_type p);
      logic [1:0] s;
      case (p)
         PH_IDLE: s = 2'd0;
         PH_SKIP, PH_LINE, PH_CR, PH_MATCH, PH_HOST, PH_DONE: s = 2'd1;
         PH_BLK, PH_BLK_SHUT: s = 2'd2;
         default: s = 2'd3;
      endcase
      return s;
   endfunction

   // hold input while the job queue is full or the back end still reads the staged name
   assign full   = fifo_full_i || busy_ff;
   assign accept = push && !full;
   assign cur_stream = stream_of(phase_ff);
   assign enable_in  = csr_write_enable ? csr_write_data : enable_ff;

   always_comb begin
      ph         = phase_ff;
      ln         = len_ff;
      mp         = mp_ff;
      emitted    = 1'b0;
      job_push_o = 1'b0;
      job_o.kind = hhf_pkg::JOB_JUDGE;
      job_o.mac  = req_data.station_mac;
      job_o.len  = '0;
      stg_wr_o.we   = 1'b0;
      stg_wr_o.addr = hhf_pkg::LEN_MAX_W'(len_ff);
      stg_wr_o.data = req_data.data_byte;
      busy_in = stg_release_i ? 1'b0 : busy_ff;

      if (accept && req_data.opcode != hhf_pkg::OP_NONE) begin
         // a byte of another stream drops the unfinished item
         if (cur_stream != 2'd0 && cur_stream != req_data.opcode + 2'd1) begin
            ph = PH_IDLE;
            ln = '0;
            mp = 3'd0;
         end
         if (req_data.opcode == hhf_pkg::OP_PAYLOAD) begin
            case (ph)
               PH_IDLE: begin
                  ln = '0;
                  mp = 3'd0;
                  if (!enable_ff) begin
                     job_o.kind = hhf_pkg::JOB_DISABLED;
                     emitted = 1'b1;
                     ph = PH_SKIP;
                  end else if (req_data.data_byte == hhf_pkg::CH_G ||
                               req_data.data_byte == hhf_pkg::CH_P ||
                               req_data.data_byte == hhf_pkg::CH_H) begin
                     ph = PH_LINE;
                  end else begin
                     job_o.kind = hhf_pkg::JOB_NO_METHOD;
                     emitted = 1'b1;
                     ph = PH_SKIP;
                  end
               end
               PH_LINE: begin
                  if (req_data.data_byte == hhf_pkg::CH_CR) ph = PH_CR;
               end
               PH_CR: begin
                  if (req_data.data_byte == hhf_pkg::CH_LF) begin
                     ph = PH_MATCH;
                     mp = 3'd0;
                  end else if (req_data.data_byte != hhf_pkg::CH_CR) begin
                     ph = PH_LINE;
                  end
               end
               PH_MATCH: begin
                  if (req_data.data_byte == hhf_pkg::host_key(mp)) begin
                     mp = mp + 3'd1;
                     if (mp == hhf_pkg::HOST_KEY_LEN) begin
                        ph = PH_HOST;
                        ln = '0;
                     end
                  end else begin
                     ph = (req_data.data_byte == hhf_pkg::CH_CR) ? PH_CR : PH_LINE;
                  end
               end
               PH_HOST: begin
                  if (req_data.data_byte == hhf_pkg::CH_CR ||
                      req_data.data_byte == hhf_pkg::CH_LF ||
                      req_data.data_byte == hhf_pkg::CH_NUL) begin
                     ph = PH_DONE;
                  end else if (ln < LW'(NAME_BYTES - 1)) begin
                     stg_wr_o.we   = 1'b1;
                     stg_wr_o.addr = hhf_pkg::LEN_MAX_W'(ln);
                     ln = ln + LW'(1);
                     if (ln >= LW'(NAME_BYTES - 1)) ph = PH_DONE;
                  end else begin
                     ph = PH_DONE;
                  end
               end
               default: begin
               end
            endcase
            if (req_data.last) begin
               if (!emitted) begin
                  job_o.kind = hhf_pkg::JOB_JUDGE;
                  emitted = 1'b1;
               end
               ph = PH_IDLE;
               mp = 3'd0;
            end
         end else begin
            if (ph == PH_IDLE) begin
               ln = '0;
               ph = (req_data.opcode == hhf_pkg::OP_BLACK) ? PH_BLK : PH_WHT;
            end
            if (ph == PH_BLK || ph == PH_WHT) begin
               if (req_data.data_byte == hhf_pkg::CH_NUL) begin
                  ph = (ph == PH_BLK) ? PH_BLK_SHUT : PH_WHT_SHUT;
               end else if (ln < LW'(NAME_BYTES)) begin
                  stg_wr_o.we   = 1'b1;
                  stg_wr_o.addr = hhf_pkg::LEN_MAX_W'(ln);
                  ln = ln + LW'(1);
               end
            end
            if (req_data.last) begin
               ph = PH_IDLE;
               job_o.kind = (req_data.opcode == hhf_pkg::OP_BLACK) ?
                            hhf_pkg::JOB_BLACK_INS : hhf_pkg::JOB_WHITE_INS;
               emitted = 1'b1;
            end
         end
         job_o.len  = hhf_pkg::LEN_MAX_W'(ln);
         job_push_o = emitted;
         if (emitted && job_o.kind != hhf_pkg::JOB_DISABLED &&
             job_o.kind != hhf_pkg::JOB_NO_METHOD) begin
            busy_in = 1'b1;
         end
      end
      phase_in = ph;
      len_in   = ln;
      mp_in    = mp;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         len_ff    <= '0;
         mp_ff     <= 3'd0;
         enable_ff <= 1'b0;
         busy_ff   <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         len_ff    <= len_in;
         mp_ff     <= mp_in;
         enable_ff <= enable_in;
         busy_ff   <= busy_in;
      end
   end

endmodule

@@ design/hhf_back.sv @@
module hhf_back #(
   parameter int NAME_BYTES    = hhf_pkg::NAME_BYTES_DEF,
   parameter int BLACK_ENTRIES = hhf_pkg::BLACK_ENTRIES_DEF,
   parameter int WHITE_ENTRIES = hhf_pkg::WHITE_ENTRIES_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  hhf_pkg::stg_wr_type stg_wr_i,
   input  logic                fifo_empty_i,
   input  hhf_pkg::job_type    fifo_job_i,
   output logic                fifo_pop_o,
   output logic                stg_release_o,
   output logic                empty,
   input  logic                pop,
   output hhf_pkg::rsp_type    rsp_data
);

   localparam int LW  = $clog2(NAME_BYTES + 1);
   localparam int IW  = (NAME_BYTES > 1) ? $clog2(NAME_BYTES) : 1;
   localparam int BEW = (BLACK_ENTRIES > 1) ? $clog2(BLACK_ENTRIES) : 1;
   localparam int WEW = (WHITE_ENTRIES > 1) ? $clog2(WHITE_ENTRIES) : 1;
   localparam int XW  = (BEW > WEW) ? BEW : WEW;
   localparam int BAW = $clog2(BLACK_ENTRIES * NAME_BYTES);
   localparam int WAW = $clog2(WHITE_ENTRIES * NAME_BYTES);

   typedef enum logic [5:0] {
      E_IDLE = 6'b000001,
      E_INFO = 6'b000010,
      E_CHK  = 6'b000100,
      E_CMP  = 6'b001000,
      E_COPY = 6'b010000,
      E_OUT  = 6'b100000
   } eng_type;

   // stores
   logic [7:0]       stg_mem [NAME_BYTES];
   logic [7:0]       black_mem [BLACK_ENTRIES * NAME_BYTES];
   logic [7:0]       white_mem [WHITE_ENTRIES * NAME_BYTES];
   logic [LW-1:0]    black_len_mem [BLACK_ENTRIES];
   logic [48+LW-1:0] white_info_mem [WHITE_ENTRIES];
   logic [7:0]       stg_q, black_q, white_q;
   logic [LW-1:0]    black_len_q;
   logic [48+LW-1:0] white_info_q;

   eng_type          state_ff, state_in;
   hhf_pkg::job_type job_ff, job_in;
   logic             list_white_ff, list_white_in;
   logic [XW-1:0]    idx_ff, idx_in;
   logic [LW-1:0]    pos_ff, pos_in;
   logic [LW-1:0]    row_len_ff, row_len_in;
   logic             wr_v_ff, wr_v_in;
   logic [LW-1:0]    wr_pos_ff, wr_pos_in;
   logic [BEW-1:0]   black_slot_ff, black_slot_in;
   logic [WEW-1:0]   white_slot_ff, white_slot_in;
   logic [BLACK_ENTRIES-1:0] black_vld_ff, black_vld_in;
   logic [WHITE_ENTRIES-1:0] white_vld_ff, white_vld_in;
   logic [31:0]      total_ff, total_in;
   hhf_pkg::rsp_type res_ff, res_in;
   hhf_pkg::rsp_type out_ff, out_in;
   logic             out_v_ff, out_v_in;

   logic [LW-1:0]    job_len;
   logic [LW-1:0]    rd_pos;
   logic [BAW-1:0]   black_rd_addr, black_wr_addr;
   logic [WAW-1:0]   white_rd_addr, white_wr_addr;
   logic [BEW-1:0]   bidx;
   logic [WEW-1:0]   widx;
   logic [LW-1:0]    row_len_sel;
   logic [47:0]      row_mac;
   logic [7:0]       stored_byte;
   logic             name_we, info_we;
   logic             list_end;
   logic             ent_hit, ent_skip;

   assign job_len = job_ff.len[LW-1:0];
   assign bidx    = idx_ff[BEW-1:0];
   assign widx    = idx_ff[WEW-1:0];

   always_comb begin
      case (state_ff)
         E_CHK:   rd_pos = '0;
         E_CMP:   rd_pos = pos_ff + LW'(1);
         default: rd_pos = pos_ff;
      endcase
   end

   assign black_rd_addr = BAW'(bidx) * BAW'(NAME_BYTES) + BAW'(rd_pos);
   assign white_rd_addr = WAW'(widx) * WAW'(NAME_BYTES) + WAW'(rd_pos);
   assign black_wr_addr = BAW'(black_slot_ff) * BAW'(NAME_BYTES) + BAW'(wr_pos_ff);
   assign white_wr_addr = WAW'(white_slot_ff) * WAW'(NAME_BYTES) + WAW'(wr_pos_ff);

   // rows never written read as empty names with a zero mac
   assign row_len_sel = list_white_ff ?
                        (white_vld_ff[widx] ? white_info_q[LW-1:0] : '0) :
                        (black_vld_ff[bidx] ? black_len_q : '0);
   assign row_mac     = white_vld_ff[widx] ? white_info_q[48+LW-1:LW] : 48'd0;
   assign stored_byte = (pos_ff < row_len_ff) ?
                        (list_white_ff ? white_q : black_q) : 8'h00;
   assign list_end    = list_white_ff ? (idx_ff == XW'(WHITE_ENTRIES - 1)) :
                                        (idx_ff == XW'(BLACK_ENTRIES - 1));
   assign name_we     = (state_ff == E_COPY) && wr_v_ff;

   always_comb begin
      ent_hit  = 1'b0;
      ent_skip = 1'b0;
      if (state_ff == E_CHK) begin
         if (list_white_ff && row_mac != job_ff.mac) ent_skip = 1'b1;
         else if (job_len == '0) ent_hit = 1'b1;
      end else if (state_ff == E_CMP) begin
         if (stored_byte != stg_q) ent_skip = 1'b1;
         else if (pos_ff == job_len - LW'(1)) ent_hit = 1'b1;
      end
   end

   always_comb begin
      state_in      = state_ff;
      job_in        = job_ff;
      list_white_in = list_white_ff;
      idx_in        = idx_ff;
      pos_in        = pos_ff;
      row_len_in    = row_len_ff;
      wr_v_in       = 1'b0;
      wr_pos_in     = wr_pos_ff;
      black_slot_in = black_slot_ff;
      white_slot_in = white_slot_ff;
      black_vld_in  = black_vld_ff;
      white_vld_in  = white_vld_ff;
      total_in      = total_ff;
      res_in        = res_ff;
      fifo_pop_o    = 1'b0;
      stg_release_o = 1'b0;
      info_we       = 1'b0;
      out_v_in      = out_v_ff && !pop;
      out_in        = out_ff;

      case (state_ff)
         E_IDLE: begin
            if (!fifo_empty_i) begin
               fifo_pop_o = 1'b1;
               job_in     = fifo_job_i;
               idx_in     = '0;
               pos_in     = '0;
               res_in.verdict        = 1'b0;
               res_in.host_length    = 8'd0;
               res_in.redirect_count = total_ff;
               case (fifo_job_i.kind)
                  hhf_pkg::JOB_DISABLED: begin
                     res_in.reason = hhf_pkg::REASON_DISABLED;
                     state_in = E_OUT;
                  end
                  hhf_pkg::JOB_NO_METHOD: begin
                     res_in.reason = hhf_pkg::REASON_NO_METHOD;
                     state_in = E_OUT;
                  end
                  hhf_pkg::JOB_JUDGE: begin
                     if (fifo_job_i.len == '0) begin
                        res_in.reason = hhf_pkg::REASON_NO_HOST;
                        state_in      = E_OUT;
                        stg_release_o = 1'b1;
                     end else begin
                        list_white_in = 1'b1;
                        state_in      = E_INFO;
                     end
                  end
                  hhf_pkg::JOB_WHITE_INS: begin
                     list_white_in = 1'b1;
                     state_in      = E_INFO;
                  end
                  default: begin
                     list_white_in = 1'b0;
                     state_in      = E_COPY;
                  end
               endcase
            end
         end
         E_INFO: begin
            state_in = E_CHK;
         end
         E_CHK, E_CMP: begin
            if (state_ff == E_CHK) begin
               row_len_in = row_len_sel;
               pos_in     = '0;
               state_in   = E_CMP;
            end else begin
               pos_in = pos_ff + LW'(1);
            end
            res_in.host_length = hhf_pkg::sat_len(job_ff.len);
            if (ent_hit) begin
               stg_release_o = 1'b1;
               state_in      = E_OUT;
               if (job_ff.kind == hhf_pkg::JOB_WHITE_INS) begin
                  res_in.reason = hhf_pkg::REASON_DUPLICATE;
               end else if (list_white_ff) begin
                  res_in.reason = hhf_pkg::REASON_WHITE;
               end else begin
                  total_in = (total_ff == 32'hFFFF_FFFF) ? total_ff : total_ff + 32'd1;
                  res_in.verdict        = 1'b1;
                  res_in.reason         = hhf_pkg::REASON_BLACK;
                  res_in.redirect_count = total_in;
               end
            end else if (ent_skip) begin
               if (!list_end) begin
                  idx_in   = idx_ff + XW'(1);
                  state_in = E_INFO;
               end else if (job_ff.kind == hhf_pkg::JOB_WHITE_INS) begin
                  pos_in   = '0;
                  state_in = E_COPY;
               end else if (list_white_ff) begin
                  list_white_in = 1'b0;
                  idx_in        = '0;
                  state_in      = E_INFO;
               end else begin
                  res_in.reason = hhf_pkg::REASON_UNLISTED;
                  stg_release_o = 1'b1;
                  state_in      = E_OUT;
               end
            end
         end
         E_COPY: begin
            if (pos_ff < job_len) begin
               wr_v_in   = 1'b1;
               wr_pos_in = pos_ff;
               pos_in    = pos_ff + LW'(1);
            end else if (!wr_v_ff) begin
               info_we = 1'b1;
               if (list_white_ff) begin
                  white_vld_in[white_slot_ff] = 1'b1;
                  white_slot_in = (white_slot_ff == WEW'(WHITE_ENTRIES - 1)) ?
                                  '0 : white_slot_ff + WEW'(1);
               end else begin
                  black_vld_in[black_slot_ff] = 1'b1;
                  black_slot_in = (black_slot_ff == BEW'(BLACK_ENTRIES - 1)) ?
                                  '0 : black_slot_ff + BEW'(1);
               end
               res_in.reason      = hhf_pkg::REASON_INSERTED;
               res_in.host_length = hhf_pkg::sat_len(job_ff.len);
               stg_release_o      = 1'b1;
               state_in           = E_OUT;
            end
         end
         E_OUT: begin
            if (!out_v_ff || pop) begin
               out_in   = res_ff;
               out_v_in = 1'b1;
               state_in = E_IDLE;
            end
         end
         default: begin
            state_in = E_IDLE;
         end
      endcase
   end

   assign empty    = !out_v_ff;
   assign rsp_data = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= E_IDLE;
         wr_v_ff       <= 1'b0;
         black_slot_ff <= '0;
         white_slot_ff <= '0;
         black_vld_ff  <= '0;
         white_vld_ff  <= '0;
         total_ff      <= 32'd0;
         out_v_ff      <= 1'b0;
      end else begin
         state_ff      <= state_in;
         wr_v_ff       <= wr_v_in;
         black_slot_ff <= black_slot_in;
         white_slot_ff <= white_slot_in;
         black_vld_ff  <= black_vld_in;
         white_vld_ff  <= white_vld_in;
         total_ff      <= total_in;
         out_v_ff      <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff        <= job_in;
      list_white_ff <= list_white_in;
      idx_ff        <= idx_in;
      pos_ff        <= pos_in;
      row_len_ff    <= row_len_in;
      wr_pos_ff     <= wr_pos_in;
      res_ff        <= res_in;
      out_ff        <= out_in;
   end

   // staging buffer
   always_ff @(posedge clock) begin
      if (stg_wr_i.we) begin
         stg_mem[stg_wr_i.addr[IW-1:0]] <= stg_wr_i.data;
      end
      stg_q <= stg_mem[rd_pos[IW-1:0]];
   end

   // name stores
   always_ff @(posedge clock) begin
      if (name_we && !list_white_ff) begin
         black_mem[black_wr_addr] <= stg_q;
      end
      black_q <= black_mem[black_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (name_we && list_white_ff) begin
         white_mem[white_wr_addr] <= stg_q;
      end
      white_q <= white_mem[white_rd_addr];
   end

   // per-row length and mac
   always_ff @(posedge clock) begin
      if (info_we && !list_white_ff) begin
         black_len_mem[black_slot_ff] <= job_len;
      end
      black_len_q <= black_len_mem[bidx];
   end

   always_ff @(posedge clock) begin
      if (info_we && list_white_ff) begin
         white_info_mem[white_slot_ff] <= {job_ff.mac, job_len};
      end
      white_info_q <= white_info_mem[widx];
   end

endmodule

@@ design/http_host_list_filter.sv @@
// HTTP host filter: payload bytes and list-insert bytes enter one per cycle
// while full is low, through a push/full queue port; one result per packet
// or inserted name leaves through an empty/pop port. At the last byte of a
// packet that carries a host, the back end walks the white list and then
// the black list: per stored row it fetches the length and mac, then
// compares the name byte by byte (a mismatch ends the row early). An
// insert copies the staged name at one byte per cycle, a white insert
// after a duplicate walk of the white list. While a host or name is
// being judged or copied, input is held off (full high); results that need
// no list work (disabled, no method) only wait for queue space. Stored rows
// carry valid bits, so no clearing pass follows reset.
module http_host_list_filter #(
   parameter int NAME_BYTES    = hhf_pkg::NAME_BYTES_DEF,
   parameter int BLACK_ENTRIES = hhf_pkg::BLACK_ENTRIES_DEF,
   parameter int WHITE_ENTRIES = hhf_pkg::WHITE_ENTRIES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   // input transactions
   input  logic             push,
   output logic             full,
   input  hhf_pkg::req_type req_data,
   // result transactions
   output logic             empty,
   input  logic             pop,
   output hhf_pkg::rsp_type rsp_data,
   // filter enable register
   input  logic             csr_write_enable,
   input  logic             csr_write_data
);

   // parser to job queue
   logic                fifo_push;
   logic                fifo_full;
   logic                fifo_empty;
   logic                fifo_pop;
   hhf_pkg::job_type    job_to_fifo;
   hhf_pkg::job_type    job_from_fifo;
   // staging buffer write and release handshake
   hhf_pkg::stg_wr_type stg_wr;
   logic                stg_release;

   // front end: parses bytes, stages the host or name, queues jobs
   hhf_front #(
      .NAME_BYTES(NAME_BYTES)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_data        (req_data),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data),
      .fifo_full_i     (fifo_full),
      .stg_release_i   (stg_release),
      .job_push_o      (fifo_push),
      .job_o           (job_to_fifo),
      .stg_wr_o        (stg_wr)
   );

   // two-deep job queue decouples parsing from list work
   hhf_job_fifo u_fifo (
      .clock  (clock),
      .reset  (reset),
      .push_i (fifo_push),
      .data_i (job_to_fifo),
      .pop_i  (fifo_pop),
      .full_o (fifo_full),
      .empty_o(fifo_empty),
      .data_o (job_from_fifo)
   );

   // back end: list walks, inserts, redirect counter, result register
   hhf_back #(
      .NAME_BYTES   (NAME_BYTES),
      .BLACK_ENTRIES(BLACK_ENTRIES),
      .WHITE_ENTRIES(WHITE_ENTRIES)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .stg_wr_i     (stg_wr),
      .fifo_empty_i (fifo_empty),
      .fifo_job_i   (job_from_fifo),
      .fifo_pop_o   (fifo_pop),
      .stg_release_o(stg_release),
      .empty        (empty),
      .pop          (pop),
      .rsp_data     (rsp_data)
   );

endmodule

@@ design/hhf_checker.sv @@
module hhf_checker (
   input logic             clock,
   input logic             reset,
   input logic             push,
   input logic             full,
   input hhf_pkg::req_type req_data,
   input logic             empty,
   input logic             pop,
   input hhf_pkg::rsp_type rsp_data,
   input logic             csr_write_enable,
   input logic             csr_write_data
);

   // no result survives reset
   assert property (@(posedge clock) reset |=> empty)
      else $error("result present after reset");

   // redirect goes with a black-list reason and only with it
   assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_data.verdict == (rsp_data.reason == hhf_pkg::REASON_BLACK)))
      else $error("verdict and reason disagree");

   // early-decided results carry no host length
   assert property (@(posedge clock) disable iff (reset)
      (!empty && (rsp_data.reason == hhf_pkg::REASON_DISABLED ||
                  rsp_data.reason == hhf_pkg::REASON_NO_METHOD ||
                  rsp_data.reason == hhf_pkg::REASON_NO_HOST))
      |-> rsp_data.host_length == 8'd0)
      else $error("host length on early result");

   // a waiting result holds until popped
   assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_data)))
      else $error("waiting result changed");

endmodule

bind http_host_list_filter hhf_checker u_hhf_checker (.*);

@@ sim/tb_http_host_list_filter.sv @@
`timescale 1ns / 100ps

module tb_http_host_list_filter;

   localparam int NB = hhf_pkg::NAME_BYTES_DEF;
   localparam int NBLK = hhf_pkg::BLACK_ENTRIES_DEF;
   localparam int NWHT = hhf_pkg::WHITE_ENTRIES_DEF;
   localparam int STALL_LIMIT = 200000;
   localparam int SETTLE_CYCLES = 20000;
   localparam int PHASE_ITEMS = 95;

   // parser phases of the predictor
   typedef enum int {
      PH_IDLE, PH_SKIP, PH_LINE, PH_CR, PH_MATCH, PH_HOST, PH_DONE,
      PH_BLK, PH_BLK_SHUT, PH_WHT, PH_WHT_SHUT
   } phase_type;

   logic clock = 1'b0;
   logic reset;
   logic push;
   logic full;
   hhf_pkg::req_type req_data;
   logic empty;
   logic pop;
   hhf_pkg::rsp_type rsp_data;
   logic csr_write_enable;
   logic csr_write_data;

   http_host_list_filter dut (
      .clock(clock), .reset(reset),
      .push(push), .full(full), .req_data(req_data),
      .empty(empty), .pop(pop), .rsp_data(rsp_data),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // filter state mirror
   logic [7:0]  blk_name [NBLK][NB];
   logic [7:0]  wht_name [NWHT][NB];
   logic [47:0] wht_mac [NWHT];
   int          blk_slot, wht_slot;
   logic [7:0]  stage [NB];
   int          stage_len;
   phase_type   phase;
   int          key_pos;
   logic [31:0] redirects;
   logic        enable_mirror;

   hhf_pkg::rsp_type verdict_queue [$];
   hhf_pkg::rsp_type last_rsp;
   bit      failed = 0;
   int      idle_pct_tx = 0;
   int      idle_pct_rx = 0;
   bit      rx_hold = 0;
   int      quiet_cycles = 0;
   int      sent = 0;
   int      budget;

   function automatic logic [7:0] key_char(int p);
      case (p)
         0: return "H";
         1: return "o";
         2: return "s";
         3: return "t";
         4: return ":";
         default: return " ";
      endcase
   endfunction

   function automatic hhf_pkg::rsp_type make_rsp(logic v, hhf_pkg::reason_type r, int len);
      hhf_pkg::rsp_type x;
      x.verdict = v;
      x.reason = r;
      x.host_length = (len > 255) ? 8'hFF : len[7:0];
      x.redirect_count = redirects;
      return x;
   endfunction

   // staged name is a prefix of a stored row
   function automatic bit prefix_of_black(int row);
      for (int i = 0; i < stage_len; i++)
         if (blk_name[row][i] != stage[i]) return 0;
      return 1;
   endfunction

   function automatic bit prefix_of_white(int row);
      for (int i = 0; i < stage_len; i++)
         if (wht_name[row][i] != stage[i]) return 0;
      return 1;
   endfunction

   function automatic bit white_listed(logic [47:0] mac);
      for (int i = 0; i < NWHT; i++)
         if (wht_mac[i] == mac && prefix_of_white(i)) return 1;
      return 0;
   endfunction

   task automatic clear_filter_state();
      for (int r = 0; r < NBLK; r++)
         for (int i = 0; i < NB; i++) blk_name[r][i] = 8'h00;
      for (int r = 0; r < NWHT; r++) begin
         wht_mac[r] = '0;
         for (int i = 0; i < NB; i++) wht_name[r][i] = 8'h00;
      end
      blk_slot = 0;
      wht_slot = 0;
      stage_len = 0;
      phase = PH_IDLE;
      key_pos = 0;
      redirects = '0;
      enable_mirror = 1'b0;
   endtask

   // verdict for a finished packet with a host (or not)
   function automatic hhf_pkg::rsp_type judge_host(logic [47:0] mac);
      bit hit;
      if (stage_len == 0) return make_rsp(1'b0, hhf_pkg::REASON_NO_HOST, 0);
      if (white_listed(mac)) return make_rsp(1'b0, hhf_pkg::REASON_WHITE, stage_len);
      hit = 0;
      for (int i = 0; i < NBLK; i++) if (prefix_of_black(i)) hit = 1;
      if (hit) begin
         if (redirects != 32'hFFFF_FFFF) redirects++;
         return make_rsp(1'b1, hhf_pkg::REASON_BLACK, stage_len);
      end
      return make_rsp(1'b0, hhf_pkg::REASON_UNLISTED, stage_len);
   endfunction

   task automatic predict_payload(hhf_pkg::req_type t, output bit has,
                                  output hhf_pkg::rsp_type r);
      logic [7:0] b;
      b = t.data_byte;
      has = 0;
      case (phase)
         PH_IDLE: begin
            stage_len = 0;
            key_pos = 0;
            if (!enable_mirror) begin
               r = make_rsp(1'b0, hhf_pkg::REASON_DISABLED, 0);
               has = 1;
               phase = PH_SKIP;
            end else if (b == hhf_pkg::CH_G || b == hhf_pkg::CH_P || b == hhf_pkg::CH_H) begin
               phase = PH_LINE;
            end else begin
               r = make_rsp(1'b0, hhf_pkg::REASON_NO_METHOD, 0);
               has = 1;
               phase = PH_SKIP;
            end
         end
         PH_LINE: if (b == hhf_pkg::CH_CR) phase = PH_CR;
         PH_CR: begin
            if (b == hhf_pkg::CH_LF) begin
               phase = PH_MATCH;
               key_pos = 0;
            end else if (b != hhf_pkg::CH_CR) begin
               phase = PH_LINE;
            end
         end
         PH_MATCH: begin
            if (key_pos < 6 && b == key_char(key_pos)) begin
               key_pos++;
               if (key_pos == 6) begin
                  phase = PH_HOST;
                  stage_len = 0;
               end
            end else begin
               phase = (b == hhf_pkg::CH_CR) ? PH_CR : PH_LINE;
            end
         end
         PH_HOST: begin
            if (b == hhf_pkg::CH_CR || b == hhf_pkg::CH_LF || b == hhf_pkg::CH_NUL) begin
               phase = PH_DONE;
            end else if (stage_len < NB - 1) begin
               stage[stage_len] = b;
               stage_len++;
               if (stage_len >= NB - 1) phase = PH_DONE;
            end else begin
               phase = PH_DONE;
            end
         end
         default: ;
      endcase
      if (t.last) begin
         if (!has) begin
            r = judge_host(t.station_mac);
            has = 1;
         end
         phase = PH_IDLE;
         key_pos = 0;
      end
   endtask

   task automatic predict_name(hhf_pkg::req_type t, output bit has,
                               output hhf_pkg::rsp_type r);
      bit black;
      black = (t.opcode == hhf_pkg::OP_BLACK);
      has = 0;
      if (phase == PH_IDLE) begin
         stage_len = 0;
         phase = black ? PH_BLK : PH_WHT;
      end
      if (phase == PH_BLK || phase == PH_WHT) begin
         if (t.data_byte == hhf_pkg::CH_NUL) phase = black ? PH_BLK_SHUT : PH_WHT_SHUT;
         else if (stage_len < NB) begin
            stage[stage_len] = t.data_byte;
            stage_len++;
         end
      end
      if (!t.last) return;
      phase = PH_IDLE;
      has = 1;
      if (black) begin
         for (int i = 0; i < NB; i++)
            blk_name[blk_slot][i] = (i < stage_len) ? stage[i] : 8'h00;
         blk_slot = (blk_slot + 1) % NBLK;
         r = make_rsp(1'b0, hhf_pkg::REASON_INSERTED, stage_len);
         return;
      end
      if (white_listed(t.station_mac)) begin
         r = make_rsp(1'b0, hhf_pkg::REASON_DUPLICATE, stage_len);
         return;
      end
      wht_mac[wht_slot] = t.station_mac;
      for (int i = 0; i < NB; i++)
         wht_name[wht_slot][i] = (i < stage_len) ? stage[i] : 8'h00;
      wht_slot = (wht_slot + 1) % NWHT;
      r = make_rsp(1'b0, hhf_pkg::REASON_INSERTED, stage_len);
   endtask

   // one accepted transaction through the predictor
   task automatic predict_item(hhf_pkg::req_type t);
      bit has;
      hhf_pkg::rsp_type r;
      int owner;
      has = 0;
      if (t.opcode == hhf_pkg::OP_NONE) return;
      // a byte from another stream drops the unfinished item
      if (phase == PH_IDLE) owner = 0;
      else if (phase <= PH_DONE) owner = 1;
      else if (phase <= PH_BLK_SHUT) owner = 2;
      else owner = 3;
      if (owner != 0 && owner != t.opcode + 1) begin
         phase = PH_IDLE;
         stage_len = 0;
         key_pos = 0;
      end
      if (t.opcode == hhf_pkg::OP_PAYLOAD) predict_payload(t, has, r);
      else predict_name(t, has, r);
      if (has) verdict_queue.push_back(r);
   endtask

   // accepted transactions on both sides
   always @(posedge clock) begin
      if (!reset) begin
         if (push && !full) predict_item(req_data);
         if (pop && !empty) begin
            last_rsp = rsp_data;
            if (verdict_queue.size() == 0) begin
               $display("%0t: unexpected result %p", $time, rsp_data);
               failed = 1;
            end else begin
               hhf_pkg::rsp_type e;
               e = verdict_queue.pop_front();
               if (rsp_data !== e) begin
                  $display("%0t: mismatch expected %p actual %p", $time, e, rsp_data);
                  failed = 1;
               end
            end
         end
         if ((push && !full) || (pop && !empty)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
      end
   end

   // watchdog on lack of progress
   always @(posedge clock) begin
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // receiver: random stalls, or a long hold-off on request
   always @(posedge clock) begin
      if (reset) pop <= 1'b0;
      else pop <= !rx_hold && ($urandom_range(99) >= idle_pct_rx);
   end

   // directed rows; known rows carry a typed-in result
   typedef struct {
      hhf_pkg::req_type t;
      bit               known;
      hhf_pkg::rsp_type r;
   } row_type;
   row_type directed [$];

   function automatic hhf_pkg::req_type mk(hhf_pkg::opcode_type op, logic [7:0] b, logic l,
                                           logic [47:0] m);
      hhf_pkg::req_type t;
      t.opcode = op;
      t.data_byte = b;
      t.last = l;
      t.station_mac = m;
      return t;
   endfunction

   task automatic add_row(hhf_pkg::req_type t);
      row_type w;
      w.t = t;
      w.known = 0;
      w.r = '0;
      directed.push_back(w);
   endtask

   task automatic add_known(hhf_pkg::req_type t, logic v, hhf_pkg::reason_type rs,
                            logic [7:0] len);
      row_type w;
      w.t = t;
      w.known = 1;
      w.r.verdict = v;
      w.r.reason = rs;
      w.r.host_length = len;
      w.r.redirect_count = '0;
      directed.push_back(w);
   endtask

   // push stays high after the accepting edge; the next send or a drain moves it
   task automatic send(hhf_pkg::req_type t);
      while ($urandom_range(99) < idle_pct_tx) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push <= 1'b1;
      req_data <= t;
      @(posedge clock);
      while (full) @(posedge clock);
      sent++;
   endtask

   task automatic drain();
      push <= 1'b0;
      while (verdict_queue.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES / 10) @(posedge clock);
   endtask

   task automatic write_enable(logic v);
      drain();
      csr_write_enable <= 1'b1;
      csr_write_data <= v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      enable_mirror = v;
   endtask

   task automatic send_text(hhf_pkg::opcode_type op, string s, logic [47:0] m, bit end_it);
      for (int i = 0; i < s.len(); i++)
         send(mk(op, s[i], end_it && (i == s.len() - 1), m));
   endtask

   // random host names from a small alphabet so that prefixes collide
   function automatic string rand_name(int maxlen);
      string s;
      int n;
      s = "";
      n = $urandom_range(maxlen);
      for (int i = 0; i < n; i++) s = {s, string'(8'(8'h61 + $urandom_range(2)))};
      return s;
   endfunction

   function automatic logic [47:0] rand_mac();
      case ($urandom_range(3))
         0: return '0;
         1: return '1;
         default: return 48'(($urandom_range(1) ? 48'hA0 : 48'h0) | $urandom_range(1));
      endcase
   endfunction

   // well-formed request with random method, headers and host
   task automatic send_request(logic [47:0] m);
      string meth, s;
      case ($urandom_range(2))
         0: meth = "GET /";
         1: meth = "POST /";
         default: meth = "HEAD /";
      endcase
      s = {meth, "\r\n"};
      if ($urandom_range(3) == 0) s = {s, "Hos: x\r\n"};
      if ($urandom_range(5) != 0) s = {s, "Host: ", rand_name(6), "\r\n"};
      if ($urandom_range(2) == 0) s = {s, "Host: b\r\n"};
      s = {s, "\r\n"};
      send_text(hhf_pkg::OP_PAYLOAD, s, m, 1);
   endtask

   task automatic send_noise();
      hhf_pkg::req_type t;
      t.opcode = 2'($urandom_range(3));
      t.data_byte = 8'($urandom_range(255));
      t.last = 1'($urandom_range(1));
      t.station_mac = 48'({$urandom, $urandom});
      send(t);
   endtask

   initial begin
      reset = 1'b1;
      push = 1'b0;
      req_data = '0;
      csr_write_enable = 1'b0;
      csr_write_data = 1'b0;
      clear_filter_state();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows: disabled, method errors, extremes, streams
      add_known(mk(hhf_pkg::OP_PAYLOAD, 8'h47, 1'b1, '0), 1'b0,
                hhf_pkg::REASON_DISABLED, 8'd0);
      add_row(mk(hhf_pkg::OP_NONE, 8'hFF, 1'b1, '1));
      foreach (directed[i]) begin
         if (directed[i].known) begin
            drain();
            send(directed[i].t);
            drain();
            if (last_rsp !== directed[i].r) begin
               $display("%0t: mismatch expected %p actual %p", $time,
                  directed[i].r, last_rsp);
               failed = 1;
            end
         end else begin
            send(directed[i].t);
         end
      end
      write_enable(1'b1);
      directed.delete();
      add_row(mk(hhf_pkg::OP_PAYLOAD, 8'hFF, 1'b0, '1));
      add_row(mk(hhf_pkg::OP_PAYLOAD, 8'h00, 1'b1, '1));
      add_row(mk(hhf_pkg::OP_PAYLOAD, 8'h48, 1'b1, '0));
      add_row(mk(hhf_pkg::OP_BLACK, 8'h00, 1'b1, '0));
      add_row(mk(hhf_pkg::OP_WHITE, 8'h61, 1'b0, '1));
      add_row(mk(hhf_pkg::OP_BLACK, 8'h62, 1'b1, '1));
      add_row(mk(hhf_pkg::OP_WHITE, 8'h61, 1'b1, '1));
      add_row(mk(hhf_pkg::OP_WHITE, 8'h61, 1'b1, '1));
      add_row(mk(hhf_pkg::OP_PAYLOAD, 8'h50, 1'b0, '1));
      add_row(mk(hhf_pkg::OP_BLACK, 8'h63, 1'b1, '0));
      foreach (directed[i]) send(directed[i].t);
      send_text(hhf_pkg::OP_PAYLOAD, "GET\r\rx\r\nHost: b\r\n", 48'h1, 1);
      send_text(hhf_pkg::OP_PAYLOAD, "GET\r\nHost: a", '1, 1);
      send_text(hhf_pkg::OP_PAYLOAD, "GET\r\nHost: \r\n", '0, 1);
      drain();

      // random phases: none, sender idle, receiver stalling, both
      for (int p = 0; p < 4; p++) begin
         idle_pct_tx = (p == 1 || p == 3) ? ((p == 1) ? 84 : 30) : 0;
         idle_pct_rx = (p == 2 || p == 3) ? ((p == 2) ? 84 : 30) : 0;
         write_enable($urandom_range(3) != 0);
         if (p == 2) begin
            // long receiver hold-off while the sender keeps pushing
            fork
               begin
                  rx_hold = 1;
                  repeat (3000) @(posedge clock);
                  rx_hold = 0;
               end
               begin
                  for (int k = 0; k < 20; k++)
                     send_text(hhf_pkg::OP_PAYLOAD, "X", '0, 1);
                  push <= 1'b0;
               end
            join
         end
         budget = sent + PHASE_ITEMS;
         while (sent < budget) begin
            case ($urandom_range(9))
               0, 1: send_text(hhf_pkg::OP_BLACK, rand_name(5), rand_mac(), 1);
               2: send_text(hhf_pkg::OP_WHITE, rand_name(5), rand_mac(), 1);
               3: send_noise();
               default: send_request(rand_mac());
            endcase
         end
         // pause until every result is back
         drain();
      end
      write_enable(1'b0);
      send_text(hhf_pkg::OP_PAYLOAD, "GET", '0, 1);
      drain();
      repeat (SETTLE_CYCLES / 10) @(posedge clock);
      if (!failed && verdict_queue.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule
